/* sv/positional_list_store_macros.svh */
// assertion macros for the positional list store checker
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// condition and consequence in the same cycle
`define PLS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequence in the cycle after the condition
`define PLS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/pls_pkg.sv */
// shared types and constants of the positional list store
package pls_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int CMD_W    = 3;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT_AT  = 3'd0,
      CMD_REMOVE_AT  = 3'd1,
      CMD_READ_AT    = 3'd2,
      CMD_PUSH_FRONT = 3'd3,
      CMD_PUSH_BACK  = 3'd4,
      CMD_POP_FRONT  = 3'd5,
      CMD_POP_BACK   = 3'd6
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_OPEN,
      OP_CLOSE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        read;
   } cell_ctrl_type;

endpackage

/* sv/pls_cell.sv */
// one slot of the list: holds a word and shifts with its neighbors
module pls_cell #(
   parameter int DATA_WIDTH = pls_pkg::DATA_WIDTH_DEFAULT,
   parameter int IDX_W      = 4,
   parameter int INDEX      = 0
) (
   input  logic                    clock,
   input  pls_pkg::cell_ctrl_type  ctrl,
   input  logic [IDX_W-1:0]        idx,
   input  logic [DATA_WIDTH-1:0]   word,
   input  logic [DATA_WIDTH-1:0]   left_data,
   input  logic [DATA_WIDTH-1:0]   right_data,
   input  logic [DATA_WIDTH-1:0]   or_in,
   output logic [DATA_WIDTH-1:0]   data_out,
   output logic [DATA_WIDTH-1:0]   or_out
);
   import pls_pkg::*;

   localparam logic [IDX_W-1:0] SLOT = IDX_W'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (ctrl.op)
         OP_OPEN: begin
            if (SLOT > idx) begin
               data_in = left_data;
            end else if (SLOT == idx) begin
               data_in = word;
            end
         end
         OP_CLOSE: begin
            if (SLOT >= idx) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign or_out   = or_in | ((SLOT == idx) ? data_ff : '0);

endmodule

/* sv/pls_ctrl.sv */
// command decode, position checks and element count
module pls_ctrl #(
   parameter int DEPTH = pls_pkg::DEPTH_DEFAULT,
   parameter int IDX_W = $clog2(DEPTH),
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  pls_pkg::cmd_type            cmd,
   input  logic [pls_pkg::POS_W-1:0]   pos,
   output pls_pkg::cell_ctrl_type      ctrl,
   output logic [IDX_W-1:0]            idx,
   output pls_pkg::status_type         status,
   output logic [CNT_W-1:0]            count_next
);
   import pls_pkg::*;

   localparam int PW = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [PW-1:0]    pos_ext;
   logic [PW-1:0]    count_ext;
   logic             full;
   logic             empty;
   cell_ctrl_type    dec;

   assign pos_ext   = PW'(pos);
   assign count_ext = PW'(count_ff);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);

   always_comb begin
      dec.op   = OP_HOLD;
      dec.read = 1'b0;
      idx      = '0;
      status   = ST_OK;
      unique case (cmd)
         CMD_INSERT_AT: begin
            if (pos_ext > count_ext) begin
               status = ST_BADPOS;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               dec.op = OP_OPEN;
               idx    = pos_ext[IDX_W-1:0];
            end
         end
         CMD_REMOVE_AT: begin
            if (empty) begin
               status = ST_EMPTY;
            end else if (pos_ext >= count_ext) begin
               status = ST_BADPOS;
            end else begin
               dec.op   = OP_CLOSE;
               dec.read = 1'b1;
               idx      = pos_ext[IDX_W-1:0];
            end
         end
         CMD_READ_AT: begin
            if (pos_ext >= count_ext) begin
               status = ST_BADPOS;
            end else begin
               dec.read = 1'b1;
               idx      = pos_ext[IDX_W-1:0];
            end
         end
         CMD_PUSH_FRONT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               dec.op = OP_OPEN;
            end
         end
         CMD_PUSH_BACK: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               dec.op = OP_OPEN;
               idx    = count_ff[IDX_W-1:0];
            end
         end
         CMD_POP_FRONT: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               dec.op   = OP_CLOSE;
               dec.read = 1'b1;
            end
         end
         CMD_POP_BACK: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               dec.op   = OP_CLOSE;
               dec.read = 1'b1;
               idx      = IDX_W'(count_ff - CNT_W'(1));
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   always_comb begin
      ctrl       = dec;
      count_next = count_ff;
      unique case (dec.op)
         OP_OPEN:  count_next = count_ff + CNT_W'(1);
         OP_CLOSE: count_next = count_ff - CNT_W'(1);
         default:  count_next = count_ff;
      endcase
      if (!accept) begin
         ctrl.op = OP_HOLD;
      end
      count_in = accept ? count_next : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

/* sv/positional_list_store.sv */
// top level of the positional list store: command decode and a row of shifting cells
//
//  channel   handshake          payload
//  request   start / busy       req_command, req_position, req_value
//  response  rsp_strobe         rsp_data_out, rsp_status, rsp_count
//
// one transaction per cycle; busy never rises
// the cells from the index upward shift in the cycle an insert, push, remove or pop is accepted
// the response follows on the next cycle, one strobe per transaction
// reset clears the count; the stored words need no clearing
// the response cannot be stalled and is shown for one cycle only
module positional_list_store #(
   parameter int DEPTH      = pls_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = pls_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [pls_pkg::CMD_W-1:0]     req_command,
   input  logic [pls_pkg::POS_W-1:0]     req_position,
   input  logic [pls_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_strobe,
   output logic [pls_pkg::VALUE_W-1:0]   rsp_data_out,
   output logic [pls_pkg::STATUS_W-1:0]  rsp_status,
   output logic [pls_pkg::COUNT_W-1:0]   rsp_count
);
   import pls_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                  accept;
   cell_ctrl_type         ctrl;
   logic [IDX_W-1:0]      idx;
   status_type            status;
   logic [CNT_W-1:0]      count_next;
   logic [DATA_WIDTH-1:0] word;
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DATA_WIDTH-1:0] or_chain  [DEPTH+1];

   logic                  rsp_strobe_ff;
   logic [VALUE_W-1:0]    rsp_data_out_ff;
   logic [VALUE_W-1:0]    rsp_data_out_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign word   = DATA_WIDTH'(req_value);

   pls_ctrl #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .cmd        (cmd_type'(req_command)),
      .pos        (req_position),
      .ctrl       (ctrl),
      .idx        (idx),
      .status     (status),
      .count_next (count_next)
   );

   assign or_chain[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic [DATA_WIDTH-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = word;
      end else begin : g_inner_left
         assign left_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_inner_right
         assign right_data = cell_data[i+1];
      end

      pls_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .IDX_W      (IDX_W),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .idx        (idx),
         .word       (word),
         .left_data  (left_data),
         .right_data (right_data),
         .or_in      (or_chain[i]),
         .data_out   (cell_data[i]),
         .or_out     (or_chain[i+1])
      );
   end

   assign rsp_data_out_in = ctrl.read ? VALUE_W'(or_chain[DEPTH]) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_out_ff <= rsp_data_out_in;
         rsp_status_ff   <= status;
         rsp_count_ff    <= COUNT_W'(count_next);
      end
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_data_out = rsp_data_out_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

/* sv/pls_checker.sv */
// port level checks of the positional list store and their binding
`include "positional_list_store_macros.svh"

module pls_checker #(
   parameter int DEPTH = pls_pkg::DEPTH_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [pls_pkg::VALUE_W-1:0]   rsp_data_out,
   input logic [pls_pkg::STATUS_W-1:0]  rsp_status,
   input logic [pls_pkg::COUNT_W-1:0]   rsp_count,
   input logic                          rsp_strobe
);
   import pls_pkg::*;

   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

   `PLS_ASSERT_NEXT(a_strobe_per_transaction, !reset && start && !busy, rsp_strobe, "missing response")
   `PLS_ASSERT_NEXT(a_no_extra_strobe, !reset && !(start && !busy), !rsp_strobe, "unexpected response")
   `PLS_ASSERT_SAME(a_error_data_zero, rsp_strobe && rsp_status != ST_OK, rsp_data_out == '0, "data on error")
   `PLS_ASSERT_SAME(a_empty_count, rsp_strobe && rsp_status == ST_EMPTY, rsp_count == '0, "empty with count")
   `PLS_ASSERT_SAME(a_full_count, rsp_strobe && rsp_status == ST_FULL, rsp_count == FULL_COUNT, "full count")

endmodule

bind positional_list_store pls_checker #(.DEPTH(DEPTH)) u_pls_checker (.*);

/* tb/positional_list_store_checker.sv */
// checker for the positional list store: shadow list, response prediction and comparison
module positional_list_store_checker #(
   parameter int DEPTH = pls_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [pls_pkg::CMD_W-1:0]     req_command,
   input  logic [pls_pkg::POS_W-1:0]     req_position,
   input  logic [pls_pkg::VALUE_W-1:0]   req_value,
   input  logic                          rsp_strobe,
   input  logic [pls_pkg::VALUE_W-1:0]   rsp_data_out,
   input  logic [pls_pkg::STATUS_W-1:0]  rsp_status,
   input  logic [pls_pkg::COUNT_W-1:0]   rsp_count,
   output int                            error_count,
   output int                            pending_count,
   output int                            list_length
);
   import pls_pkg::*;

   typedef struct packed {
      logic [VALUE_W-1:0] data;
      status_type         status;
      logic [COUNT_W-1:0] count;
   } list_response_type;

   logic [VALUE_W-1:0] shadow_words [DEPTH];
   int unsigned        shadow_len;
   list_response_type  awaited_responses [$];

   initial begin
      error_count   = 0;
      pending_count = 0;
      list_length   = 0;
      shadow_len    = 0;
   end

   // open a gap at pos and store the word there
   function automatic void open_gap(input int unsigned pos, input logic [VALUE_W-1:0] word);
      int unsigned i;
      for (i = shadow_len; i > pos; i--) begin
         shadow_words[i] = shadow_words[i-1];
      end
      shadow_words[pos] = word;
      shadow_len++;
   endfunction

   // take the word at pos and close the gap
   function automatic logic [VALUE_W-1:0] close_gap(input int unsigned pos);
      logic [VALUE_W-1:0] word;
      int unsigned        i;
      word = shadow_words[pos];
      for (i = pos; i + 1 < shadow_len; i++) begin
         shadow_words[i] = shadow_words[i+1];
      end
      shadow_len--;
      return word;
   endfunction

   function automatic list_response_type apply_list_command(input cmd_type cmd,
                                                            input int unsigned pos,
                                                            input logic [VALUE_W-1:0] val);
      list_response_type rsp;
      rsp.data   = '0;
      rsp.status = ST_OK;
      case (cmd)
         CMD_INSERT_AT: begin
            if (pos > shadow_len) rsp.status = ST_BADPOS;
            else if (shadow_len >= DEPTH) rsp.status = ST_FULL;
            else open_gap(pos, val);
         end
         CMD_REMOVE_AT: begin
            if (shadow_len == 0) rsp.status = ST_EMPTY;
            else if (pos >= shadow_len) rsp.status = ST_BADPOS;
            else rsp.data = close_gap(pos);
         end
         CMD_READ_AT: begin
            if (pos >= shadow_len) rsp.status = ST_BADPOS;
            else rsp.data = shadow_words[pos];
         end
         CMD_PUSH_FRONT: begin
            if (shadow_len >= DEPTH) rsp.status = ST_FULL;
            else open_gap(0, val);
         end
         CMD_PUSH_BACK: begin
            if (shadow_len >= DEPTH) rsp.status = ST_FULL;
            else open_gap(shadow_len, val);
         end
         CMD_POP_FRONT: begin
            if (shadow_len == 0) rsp.status = ST_EMPTY;
            else rsp.data = close_gap(0);
         end
         CMD_POP_BACK: begin
            if (shadow_len == 0) rsp.status = ST_EMPTY;
            else rsp.data = close_gap(shadow_len - 1);
         end
         default: begin
         end
      endcase
      rsp.count = shadow_len[COUNT_W-1:0];
      return rsp;
   endfunction

   always @(posedge clock) begin
      list_response_type want;
      if (reset) begin
         shadow_len = 0;
         awaited_responses.delete();
      end else begin
         // response of an earlier transaction first, then the new transaction
         if (rsp_strobe === 1'b1) begin
            if (awaited_responses.size() == 0) begin
               $error("unexpected response: data_out %h status %0d count %0d",
                      rsp_data_out, rsp_status, rsp_count);
               error_count++;
            end else begin
               want = awaited_responses.pop_front();
               if (rsp_data_out !== want.data) begin
                  $error("data_out: expected %h, actual %h", want.data, rsp_data_out);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_count !== want.count) begin
                  $error("count: expected %0d, actual %0d", want.count, rsp_count);
                  error_count++;
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            awaited_responses.push_back(apply_list_command(cmd_type'(req_command),
                                                           req_position, req_value));
         end
      end
      pending_count <= awaited_responses.size();
      list_length   <= shadow_len;
   end

endmodule

/* tb/tb_positional_list_store.sv */
// testbench top for the positional list store: clock, reset, stimulus and verdict
module tb_positional_list_store;
   import pls_pkg::*;

   localparam int DEPTH       = 16;
   localparam int PHASE_ITEMS = 340;
   localparam int CYCLE_LIMIT = 400000;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [CMD_W-1:0]     req_command;
   logic [POS_W-1:0]     req_position;
   logic [VALUE_W-1:0]   req_value;
   logic                 rsp_strobe;
   logic [VALUE_W-1:0]   rsp_data_out;
   logic [STATUS_W-1:0]  rsp_status;
   logic [COUNT_W-1:0]   rsp_count;

   int error_count;
   int pending_count;
   int list_length;
   int sender_idle_pct;
   int cycle_count;
   bit growing;

   positional_list_store #(.DEPTH(DEPTH), .DATA_WIDTH(VALUE_W)) u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_command  (req_command),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_data_out (rsp_data_out),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count)
   );

   positional_list_store_checker #(.DEPTH(DEPTH)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_position  (req_position),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_data_out  (rsp_data_out),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count),
      .error_count   (error_count),
      .pending_count (pending_count),
      .list_length   (list_length)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_positional_list_store: done, errors");
         $finish;
      end
   end

   // one transaction, with random idle cycles ahead of it
   task automatic issue(input cmd_type cmd, input int unsigned pos, input logic [31:0] val);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_command  <= cmd;
      req_position <= pos[POS_W-1:0];
      req_value    <= val;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain;
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic run_directed;
      int k;
      issue(CMD_POP_FRONT, 0, 32'h1111_1111);
      issue(CMD_POP_BACK, 0, 32'h2222_2222);
      issue(CMD_REMOVE_AT, 0, 32'h3333_3333);
      issue(CMD_READ_AT, 0, 32'h4444_4444);
      issue(CMD_INSERT_AT, 1, 32'h5555_5555);
      issue(CMD_INSERT_AT, 0, 32'h0000_0000);
      issue(CMD_PUSH_BACK, 7, 32'hffff_ffff);
      issue(CMD_PUSH_FRONT, 16, 32'ha5a5_a5a5);
      issue(CMD_INSERT_AT, 3, 32'h1234_5678);
      issue(CMD_READ_AT, 4, 32'h0);
      issue(CMD_REMOVE_AT, 4, 32'h0);
      issue(CMD_INSERT_AT, 16, 32'h0);
      issue(CMD_REMOVE_AT, 2, 32'h0);
      // fill to the limit
      for (k = 3; k < DEPTH; k++) issue(CMD_PUSH_BACK, 0, $urandom);
      issue(CMD_PUSH_FRONT, 0, 32'hdead_beef);
      issue(CMD_PUSH_BACK, 0, 32'hdead_beef);
      issue(CMD_INSERT_AT, 16, 32'hdead_beef);
      issue(CMD_INSERT_AT, 0, 32'hdead_beef);
      issue(CMD_READ_AT, 15, 32'h0);
      issue(CMD_REMOVE_AT, 15, 32'h0);
      issue(CMD_POP_BACK, 0, 32'h0);
   endtask

   task automatic run_random_item;
      int unsigned pick;
      int unsigned len;
      cmd_type     cmd;
      int unsigned pos;
      len = list_length;
      if (len >= DEPTH) growing = 1'b0;
      else if (len == 0) growing = 1'b1;
      pick = $urandom_range(99);
      if ($urandom_range(99) < 8) begin
         // noise: any command, any position from 0 to 16
         cmd = cmd_type'($urandom_range(6));
         pos = $urandom_range(16);
      end else begin
         if (!growing) pick = 99 - pick;
         if (pick < 20) cmd = CMD_PUSH_BACK;
         else if (pick < 35) cmd = CMD_PUSH_FRONT;
         else if (pick < 55) cmd = CMD_INSERT_AT;
         else if (pick < 70) cmd = CMD_READ_AT;
         else if (pick < 80) cmd = CMD_REMOVE_AT;
         else if (pick < 90) cmd = CMD_POP_FRONT;
         else cmd = CMD_POP_BACK;
         if (cmd == CMD_INSERT_AT) pos = $urandom_range(len);
         else if (len > 0) pos = $urandom_range(len - 1);
         else pos = 0;
      end
      issue(cmd, pos, $urandom);
   endtask

   initial begin
      int phase;
      int n;
      cycle_count     = 0;
      sender_idle_pct = 32;
      growing         = 1'b1;
      reset        <= 1'b1;
      start        <= 1'b0;
      req_command  <= CMD_READ_AT;
      req_position <= '0;
      req_value    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      for (phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 82 : 0;
         drain();
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(49) == 0) drain();
            run_random_item();
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_positional_list_store: done, clean");
      end else begin
         $display("tb_positional_list_store: done, errors");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/pls_pkg.sv
sv/pls_cell.sv
sv/pls_ctrl.sv
sv/positional_list_store.sv
sv/pls_checker.sv
tb/positional_list_store_checker.sv
tb/tb_positional_list_store.sv
